[design/pmsb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the priority-masked sprite blit unit.
// No dependencies; used by pmsb_prio_map and priority_masked_sprite_blit_unit.
package pmsb_pkg;

  // Frame geometry and priority map size
  localparam int FRAME_WIDTH  = 160;
  localparam int FRAME_HEIGHT = 168;
  localparam int MAP_CELLS    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int MAP_AW       = 15;   // map_address field width
  localparam int COORD_W      = 9;    // origin + counter, before clipping

  // Sprite priority floor
  localparam logic [7:0] MIN_PRIORITY = 8'd4;

  // Operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_PIXEL = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ORIGIN_X           = 3'd0,
    CFG_ORIGIN_Y           = 3'd1,
    CFG_SPRITE_WIDTH       = 3'd2,
    CFG_SPRITE_HEIGHT      = 3'd3,
    CFG_TRANSPARENT_COLOUR = 3'd4,
    CFG_SPRITE_PRIORITY    = 3'd5
  } cfg_index_t;

  // Input beat
  typedef struct packed {
    op_t                 op;
    logic [MAP_AW-1:0]   map_address;
    logic [7:0]          map_value;
    logic [7:0]          pixel_colour;
  } item_t;

  // Result beat
  typedef struct packed {
    logic       drawn;
    logic [7:0] frame_x;
    logic [7:0] frame_y;
    logic [7:0] colour;
    logic       last_pixel;
  } result_t;

  // Priority map read and write requests
  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic              en;
    logic [MAP_AW-1:0] addr;
    logic [7:0]        data;
  } map_wr_t;

endpackage

[design/pmsb_prio_map.sv]
`timescale 1ns / 1ps
// Priority map: single-port-write, single-port-read RAM with a registered read,
// write-to-read forwarding and a clearing pass after reset. Uses pmsb_pkg.
module pmsb_prio_map (
  input  logic              clk,
  input  logic              rst,
  input  pmsb_pkg::map_rd_t rd,
  input  pmsb_pkg::map_wr_t wr,
  output logic [7:0]        rd_data,
  output logic              clearing
);

  logic [7:0]                  mem [pmsb_pkg::MAP_CELLS];
  logic [pmsb_pkg::MAP_AW-1:0] clr_addr;
  pmsb_pkg::map_wr_t           wr_eff;
  logic [7:0]                  ram_q;
  logic                        fwd_hit;
  logic [7:0]                  fwd_data;

  // Clearing pass walks every cell once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == pmsb_pkg::MAP_AW'(pmsb_pkg::MAP_CELLS - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Write port mux: clearing owns the port until done
  always_comb begin
    if (clearing) begin
      wr_eff.en   = 1'b1;
      wr_eff.addr = clr_addr;
      wr_eff.data = '0;
    end else begin
      wr_eff = wr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_eff.en) begin
      mem[wr_eff.addr] <= wr_eff.data;
    end
  end

  // Registered read; a write to the same cell on the same edge is forwarded
  always_ff @(posedge clk) begin
    if (rd.en) begin
      ram_q    <= mem[rd.addr];
      fwd_hit  <= wr_eff.en && (wr_eff.addr == rd.addr);
      fwd_data <= wr_eff.data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : ram_q;

  // Every write stays inside the map
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_eff.en |-> (wr_eff.addr < pmsb_pkg::MAP_AW'(pmsb_pkg::MAP_CELLS)))
    else $error("priority map write beyond last cell");

  // Clearing pass runs to completion without restarting
  a_clr_monotonic: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> (clr_addr == pmsb_pkg::MAP_AW'(pmsb_pkg::MAP_CELLS)))
    else $error("clearing pass ended at the wrong cell");

  // Clearing never comes back without a reset
  a_clr_once: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");

endmodule

[design/priority_masked_sprite_blit_unit.sv]
`timescale 1ns / 1ps
// Top level of the priority-masked sprite blit unit.
// Depends on pmsb_pkg and pmsb_prio_map.

// Takes one beat per cycle while item_stall is low, loads and sprite pixels
// alike. A pixel's map read launches on the edge that takes it; the compare,
// map write-back and result register follow when stage 1 advances, which a
// stalled result beat can hold off. A map write landing on the cell the next
// pixel reads is forwarded, so back-to-back pixels on the same cell see each
// other. After reset the map is cleared one cell per cycle, all 26880 cells,
// with item_stall high; configuration writes are taken throughout.
module priority_masked_sprite_blit_unit (
  input  logic              clk,
  input  logic              rst,
  // input beats
  input  logic              item_valid,
  output logic              item_stall,
  input  pmsb_pkg::item_t   item,
  // result beats
  output logic              result_valid,
  input  logic              result_stall,
  output pmsb_pkg::result_t result,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  // Configuration registers
  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic [7:0] sprite_width;
  logic [7:0] sprite_height;
  logic [7:0] transparent_colour;
  logic [7:0] sprite_priority;

  // Raster counters
  logic [7:0] column_count;
  logic [7:0] row_count;
  logic [7:0] column_count_next;
  logic [7:0] row_count_next;

  // Stage 0 signals
  logic                           accept;
  logic [pmsb_pkg::COORD_W-1:0]   fx_wide;
  logic [pmsb_pkg::COORD_W-1:0]   fy_wide;
  logic [pmsb_pkg::MAP_AW-1:0]    map_cell;
  logic [pmsb_pkg::MAP_AW-1:0]    s0_addr;
  logic                           s0_cand;
  logic [7:0]                     s0_wdata;
  logic [7:0]                     w_eff;
  logic [7:0]                     h_eff;
  logic [7:0]                     eff_prio;
  logic                           col_wrap;
  logic                           row_wrap;
  logic                           s0_last;

  // Stage 1 registers
  logic                           s1_valid;
  pmsb_pkg::op_t                  s1_op;
  logic                           s1_cand;
  logic [pmsb_pkg::MAP_AW-1:0]    s1_addr;
  logic [7:0]                     s1_wdata;
  logic [7:0]                     s1_fx;
  logic [7:0]                     s1_fy;
  logic [7:0]                     s1_colour;
  logic                           s1_last;
  logic                           s1_adv;
  logic                           s1_drawn;

  // Map interface
  pmsb_pkg::map_rd_t              map_rd;
  pmsb_pkg::map_wr_t              map_wr;
  logic [7:0]                     map_q;
  logic                           map_clearing;

  // Configuration port never back-pressures
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x           <= 8'd0;
      origin_y           <= 8'd0;
      sprite_width       <= 8'd1;
      sprite_height      <= 8'd1;
      transparent_colour <= 8'd255;
      sprite_priority    <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmsb_pkg::CFG_ORIGIN_X:           origin_x           <= cfg_data;
        pmsb_pkg::CFG_ORIGIN_Y:           origin_y           <= cfg_data;
        pmsb_pkg::CFG_SPRITE_WIDTH:       sprite_width       <= cfg_data;
        pmsb_pkg::CFG_SPRITE_HEIGHT:      sprite_height      <= cfg_data;
        pmsb_pkg::CFG_TRANSPARENT_COLOUR: transparent_colour <= cfg_data;
        pmsb_pkg::CFG_SPRITE_PRIORITY:    sprite_priority    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 drains into the result register or, for loads, just retires
  assign s1_adv     = s1_valid &&
                      (s1_op == pmsb_pkg::OP_LOAD || !result_valid || !result_stall);
  assign item_stall = map_clearing || (s1_valid && !s1_adv);
  assign accept     = item_valid && !item_stall;

  // Stage 0: place the pixel, clip it and form the map address; loads give their own
  always_comb begin
    w_eff    = (sprite_width  == 8'd0) ? 8'd1 : sprite_width;
    h_eff    = (sprite_height == 8'd0) ? 8'd1 : sprite_height;
    eff_prio = (sprite_priority < pmsb_pkg::MIN_PRIORITY) ?
               pmsb_pkg::MIN_PRIORITY : sprite_priority;
    fx_wide  = {1'b0, origin_x} + {1'b0, column_count};
    fy_wide  = {1'b0, origin_y} + pmsb_pkg::COORD_W'(1) + {1'b0, row_count};
    map_cell = pmsb_pkg::MAP_AW'(fy_wide[7:0]) * pmsb_pkg::MAP_AW'(pmsb_pkg::FRAME_WIDTH)
             + pmsb_pkg::MAP_AW'(fx_wide[7:0]);
    if (item.op == pmsb_pkg::OP_LOAD) begin
      s0_addr  = item.map_address;
      s0_cand  = item.map_address < pmsb_pkg::MAP_AW'(pmsb_pkg::MAP_CELLS);
      s0_wdata = item.map_value;
    end else begin
      s0_addr  = map_cell;
      s0_cand  = (item.pixel_colour != transparent_colour) &&
                 (fx_wide < pmsb_pkg::COORD_W'(pmsb_pkg::FRAME_WIDTH)) &&
                 (fy_wide < pmsb_pkg::COORD_W'(pmsb_pkg::FRAME_HEIGHT));
      s0_wdata = eff_prio;
    end
  end

  // Raster counter advance
  always_comb begin
    col_wrap          = ({1'b0, column_count} + 9'd1) >= {1'b0, w_eff};
    row_wrap          = ({1'b0, row_count} + 9'd1) >= {1'b0, h_eff};
    s0_last           = col_wrap && row_wrap;
    column_count_next = col_wrap ? 8'd0 : column_count + 8'd1;
    if (!col_wrap) begin
      row_count_next = row_count;
    end else if (row_wrap) begin
      row_count_next = 8'd0;
    end else begin
      row_count_next = row_count + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept && item.op == pmsb_pkg::OP_PIXEL) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Map read is issued as the beat is taken
  assign map_rd.en   = accept;
  assign map_rd.addr = s0_addr;

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= item.op;
      s1_cand   <= s0_cand;
      s1_addr   <= s0_addr;
      s1_wdata  <= s0_wdata;
      s1_fx     <= fx_wide[7:0];
      s1_fy     <= fy_wide[7:0];
      s1_colour <= item.pixel_colour;
      s1_last   <= s0_last;
    end
  end

  // Stage 1: priority compare and write-back
  assign s1_drawn    = s1_cand && (s1_wdata >= map_q);
  assign map_wr.en   = s1_adv && s1_cand &&
                       (s1_op == pmsb_pkg::OP_LOAD || s1_wdata >= map_q);
  assign map_wr.addr = s1_addr;
  assign map_wr.data = s1_wdata;

  pmsb_prio_map u_map (
    .clk      (clk),
    .rst      (rst),
    .rd       (map_rd),
    .wr       (map_wr),
    .rd_data  (map_q),
    .clearing (map_clearing)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1_op == pmsb_pkg::OP_PIXEL) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_op == pmsb_pkg::OP_PIXEL) begin
      result.drawn      <= s1_drawn;
      result.frame_x    <= s1_drawn ? s1_fx : 8'd0;
      result.frame_y    <= s1_drawn ? s1_fy : 8'd0;
      result.colour     <= s1_drawn ? s1_colour : 8'd0;
      result.last_pixel <= s1_last;
    end
  end

  // No beat is taken while the map is being cleared
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    map_clearing |-> item_stall)
    else $error("beat taken during clearing pass");

  // A drawn pixel always lies inside the frame, below the top row
  a_drawn_in_frame: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.drawn) |->
      (result.frame_x < 8'(pmsb_pkg::FRAME_WIDTH)) &&
      (result.frame_y < 8'(pmsb_pkg::FRAME_HEIGHT)) && (result.frame_y != 8'd0))
    else $error("drawn pixel outside frame");

  // Skipped pixels carry zero coordinates and colour
  a_skipped_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.drawn) |->
      (result.frame_x == 8'd0) && (result.frame_y == 8'd0) && (result.colour == 8'd0))
    else $error("skipped pixel carries nonzero fields");

  // While the last pixel of a sprite waits in stage 1, the counters are back at zero
  a_last_resets_counters: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op == pmsb_pkg::OP_PIXEL && s1_last) |->
      (column_count == 8'd0) && (row_count == 8'd0))
    else $error("raster counters not rewound after last pixel");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for priority_masked_sprite_blit_unit: a scoreboard class
// keeps its own priority map, sprite counters and registers to predict each beat.
// Depends on pmsb_pkg and the design files under design/.
module tb_top;
  import pmsb_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int DRAIN        = 8;       // pipeline is two deep, loads give no beat
  localparam int LIMIT        = 800000;  // map clear plus worst-case gaps and stalls

  // Predicts the blit pipeline and checks result beats in order
  class blit_scoreboard;
    bit [7:0] prio_map [MAP_CELLS];
    bit [7:0] col_cnt, row_cnt;
    bit [7:0] org_x, org_y, spr_w, spr_h, key_colour, spr_prio;
    result_t  pending_pixels [$];
    int       errors, n_pixels, n_drawn, n_hidden, n_last, n_loads;

    function new();
      org_x      = 8'd0;
      org_y      = 8'd0;
      spr_w      = 8'd1;
      spr_h      = 8'd1;
      key_colour = 8'hFF;
      spr_prio   = MIN_PRIORITY;
    endfunction

    function void set_reg(cfg_index_t idx, bit [7:0] v);
      case (idx)
        CFG_ORIGIN_X:           org_x = v;
        CFG_ORIGIN_Y:           org_y = v;
        CFG_SPRITE_WIDTH:       spr_w = v;
        CFG_SPRITE_HEIGHT:      spr_h = v;
        CFG_TRANSPARENT_COLOUR: key_colour = v;
        CFG_SPRITE_PRIORITY:    spr_prio = v;
        default: ;
      endcase
    endfunction

    function int eff_width();
      return (spr_w == 0) ? 1 : int'(spr_w);
    endfunction

    function int eff_height();
      return (spr_h == 0) ? 1 : int'(spr_h);
    endfunction

    // Pixels still needed to finish the current sprite
    function int pixels_to_end();
      int w, h, n;
      w = eff_width();
      h = eff_height();
      n = (col_cnt + 1 >= w) ? 1 : w - col_cnt;
      if (row_cnt + 1 < h) n += (h - row_cnt - 1) * w;
      return n;
    endfunction

    // One sprite pixel: place, clip, key, priority test, then advance counters
    function result_t blit_pixel(bit [7:0] pix);
      int unsigned fx, fy, map_cell;
      bit [7:0]    prio;
      result_t     r;
      r    = '0;
      fx   = org_x + col_cnt;
      fy   = org_y + 1 + row_cnt;
      prio = (spr_prio < MIN_PRIORITY) ? MIN_PRIORITY : spr_prio;
      if (pix != key_colour && fx < FRAME_WIDTH && fy < FRAME_HEIGHT) begin
        map_cell = fy * FRAME_WIDTH + fx;
        if (prio >= prio_map[map_cell]) begin
          prio_map[map_cell] = prio;
          r.drawn   = 1'b1;
          r.frame_x = fx[7:0];
          r.frame_y = fy[7:0];
          r.colour  = pix;
        end else begin
          n_hidden++;
        end
      end
      if (col_cnt + 1 >= eff_width()) begin
        col_cnt = 8'd0;
        if (row_cnt + 1 >= eff_height()) begin
          row_cnt      = 8'd0;
          r.last_pixel = 1'b1;
        end else begin
          row_cnt = row_cnt + 8'd1;
        end
      end else begin
        col_cnt = col_cnt + 8'd1;
      end
      return r;
    endfunction

    function void accept_item(item_t it);
      if (it.op == OP_LOAD) begin
        n_loads++;
        if (it.map_address < MAP_CELLS) prio_map[it.map_address] = it.map_value;
      end else begin
        pending_pixels.push_back(blit_pixel(it.pixel_colour));
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing pending", got));
        return;
      end
      want = pending_pixels.pop_front();
      n_pixels++;
      if (want.drawn) n_drawn++;
      if (want.last_pixel) n_last++;
      if (got.drawn !== want.drawn)
        report_mismatch($sformatf("drawn %b, want %b", got.drawn, want.drawn));
      if (got.frame_x !== want.frame_x)
        report_mismatch($sformatf("frame_x %h, want %h", got.frame_x, want.frame_x));
      if (got.frame_y !== want.frame_y)
        report_mismatch($sformatf("frame_y %h, want %h", got.frame_y, want.frame_y));
      if (got.colour !== want.colour)
        report_mismatch($sformatf("colour %h, want %h", got.colour, want.colour));
      if (got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf("last_pixel %b, want %b", got.last_pixel,
                                  want.last_pixel));
    endtask
  endclass

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index    = '0;
  logic [7:0] cfg_data     = '0;

  blit_scoreboard sb = new();
  int  cycles     = 0;
  int  n_counted  = 0;
  int  n_settings = 0;
  bit  quiet      = 1'b0;   // no gaps and no stalls while set

  priority_masked_sprite_blit_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t make_pixel(bit [7:0] colour);
    item_t it;
    it.op           = OP_PIXEL;
    it.map_address  = MAP_AW'($urandom_range(0, 32767));
    it.map_value    = 8'($urandom_range(0, 255));
    it.pixel_colour = colour;
    return it;
  endfunction

  function automatic item_t make_load(int unsigned addr, bit [7:0] value);
    item_t it;
    it.op           = OP_LOAD;
    it.map_address  = MAP_AW'(addr);
    it.map_value    = value;
    it.pixel_colour = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic bit [7:0] pick_colour();
    if ($urandom_range(0, 4) == 0) return sb.key_colour;
    return 8'($urandom_range(0, 255));
  endfunction

  // Load aimed mostly at a cell under the sprite, value often near the sprite priority
  function automatic item_t pick_load();
    int unsigned fx, fy, prio, r;
    bit [7:0]    v;
    prio = (sb.spr_prio < MIN_PRIORITY) ? MIN_PRIORITY : sb.spr_prio;
    r    = $urandom_range(0, 99);
    if (r < 40)      v = 8'($urandom_range(0, 255));
    else if (r < 65) v = 8'(prio);
    else if (r < 85) v = (prio == 255) ? 8'd255 : 8'(prio + 1);
    else             v = 8'($urandom_range(0, 8));
    r = $urandom_range(0, 99);
    if (r < 8) return make_load($urandom_range(MAP_CELLS, 32767), v);
    fx = sb.org_x + $urandom_range(0, sb.eff_width() - 1);
    fy = sb.org_y + 1 + $urandom_range(0, sb.eff_height() - 1);
    if (r < 30 || fx >= FRAME_WIDTH || fy >= FRAME_HEIGHT)
      return make_load($urandom_range(0, MAP_CELLS - 1), v);
    return make_load(fy * FRAME_WIDTH + fx, v);
  endfunction

  function automatic bit [7:0] pick_origin(int last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, last - 4));
    if (r < 80) return 8'($urandom_range(last - 3, last + 1));
    if (r < 90) return 8'($urandom_range(last + 2, 255));
    if (r < 95) return 8'd0;
    return 8'd255;
  endfunction

  function automatic bit [7:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(1, 6));
    if (r < 85) return 8'($urandom_range(7, 16));
    if (r < 93) return 8'($urandom_range(17, 24));
    if (r < 97) return 8'd1;
    return 8'd0;
  endfunction

  function automatic bit [7:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'($urandom_range(0, 8));
    if (r < 35) return 8'd0;
    if (r < 40) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  // Drive one input beat after an optional gap; hold it until taken
  task automatic send_item(item_t it, int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    sb.accept_item(it);
    if (!(it.op == OP_LOAD && it.map_address >= MAP_CELLS)) n_counted++;
  endtask

  // Register write; cfg_valid stays up for back-to-back writes
  task automatic write_cfg(cfg_index_t idx, bit [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, v);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Wait until every pixel has come back and any trailing load has settled
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic random_config(int phase);
    if ($urandom_range(0, 9) < 6) write_cfg(CFG_ORIGIN_X, pick_origin(FRAME_WIDTH - 1));
    if ($urandom_range(0, 9) < 6) write_cfg(CFG_ORIGIN_Y, pick_origin(FRAME_HEIGHT - 2));
    if ($urandom_range(0, 9) < 6) write_cfg(CFG_SPRITE_WIDTH, pick_size());
    if ($urandom_range(0, 9) < 6) write_cfg(CFG_SPRITE_HEIGHT, pick_size());
    if ($urandom_range(0, 9) < 4) write_cfg(CFG_TRANSPARENT_COLOUR, pick_level());
    if ($urandom_range(0, 9) < 6) write_cfg(CFG_SPRITE_PRIORITY, pick_level());
    // one full-width row and one full-height column sprite per run
    if (phase == 3) begin
      write_cfg(CFG_SPRITE_WIDTH, 8'd255);
      write_cfg(CFG_SPRITE_HEIGHT, 8'd1);
    end else if (phase == 8) begin
      write_cfg(CFG_SPRITE_WIDTH, 8'd1);
      write_cfg(CFG_SPRITE_HEIGHT, 8'd255);
    end
    cfg_release();
  endtask

  // Mostly whole sprites with loads mixed in; some cut short or run over
  task automatic random_phase(int phase);
    int npix, r;
    wait_idle();
    quiet = ($urandom_range(0, 9) == 0);
    random_config(phase);
    npix = sb.pixels_to_end();
    r    = $urandom_range(0, 99);
    if (r < 15)      npix = $urandom_range(1, npix);
    else if (r < 25) npix = npix + $urandom_range(1, 4);
    if (npix > 300) npix = 300;
    for (int k = 0; k < npix; k++) begin
      while ($urandom_range(0, 99) < 15) send_item(pick_load(), pick_gap());
      send_item(make_pixel(pick_colour()), pick_gap());
    end
  endtask

  // Receiver stalls
  initial begin : result_stall_gen
    int free, hold;
    while (rst) @(posedge clk);
    forever begin
      result_stall <= 1'b0;
      free = 1 + pick_gap();
      repeat (free) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.check_result(result);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[%0t] timeout after %0d cycles, %0d pixels outstanding", $realtime,
               cycles, sb.pending_pixels.size());
      $display("** priority_masked_sprite_blit_unit: FAILED **");
      $finish;
    end
  end

  // Stimulus
  initial begin : stimulus
    int phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 1x1 sprite at origin (0,0), priority floor, transparency, ties
    write_cfg(CFG_ORIGIN_X, 8'd0);
    write_cfg(CFG_ORIGIN_Y, 8'd0);
    write_cfg(CFG_SPRITE_WIDTH, 8'd1);
    write_cfg(CFG_SPRITE_HEIGHT, 8'd1);
    write_cfg(CFG_TRANSPARENT_COLOUR, 8'hFF);
    write_cfg(CFG_SPRITE_PRIORITY, 8'd0);
    cfg_release();
    send_item(make_pixel(8'h00), 0);                  // drawn at (0,1)
    send_item(make_pixel(8'hFF), 0);                  // keyed out
    send_item(make_load(FRAME_WIDTH, 8'd5), 0);       // raise cell under sprite
    send_item(make_pixel(8'h3C), 0);                  // hidden behind the load
    send_item(make_load(FRAME_WIDTH, 8'd4), 0);
    send_item(make_pixel(8'hC3), 0);                  // equal priority draws
    send_item(make_pixel(8'h5A), 0);                  // same cell back to back
    send_item(make_load(32767, 8'hFF), 0);            // past the map, ignored
    send_item(make_load(MAP_CELLS, 8'hFF), 0);        // first address past the map
    send_item(make_load(MAP_CELLS - 1, 8'hFF), 0);    // bottom-right cell
    send_item(make_pixel(8'h81), 0);
    wait_idle();

    // 2x2 sprite over the bottom-right corner, top priority, key colour 0
    write_cfg(CFG_ORIGIN_X, 8'd159);
    write_cfg(CFG_ORIGIN_Y, 8'd166);
    write_cfg(CFG_SPRITE_WIDTH, 8'd2);
    write_cfg(CFG_SPRITE_HEIGHT, 8'd2);
    write_cfg(CFG_TRANSPARENT_COLOUR, 8'h00);
    write_cfg(CFG_SPRITE_PRIORITY, 8'd255);
    cfg_release();
    send_item(make_pixel(8'h7E), 0);                  // drawn over priority 255
    send_item(make_pixel(8'h11), 0);                  // clipped right
    send_item(make_pixel(8'h00), 0);                  // keyed and clipped
    send_item(make_pixel(8'h22), 0);                  // clipped, end of sprite
    wait_idle();

    // zero size reads as 1x1; far origin clips everything
    write_cfg(CFG_ORIGIN_X, 8'd255);
    write_cfg(CFG_ORIGIN_Y, 8'd255);
    write_cfg(CFG_SPRITE_WIDTH, 8'd0);
    write_cfg(CFG_SPRITE_HEIGHT, 8'd0);
    write_cfg(CFG_SPRITE_PRIORITY, 8'd3);
    cfg_release();
    send_item(make_pixel(8'hFF), 0);
    wait_idle();
    write_cfg(CFG_ORIGIN_X, 8'd0);
    write_cfg(CFG_ORIGIN_Y, 8'd0);
    cfg_release();
    send_item(make_pixel(8'h96), 0);                  // floor of 4 ties the cell
    send_item(make_load(FRAME_WIDTH, 8'hFF), 0);
    send_item(make_pixel(8'h69), 0);                  // hidden

    // random sprites
    n_counted = 0;
    phase     = 0;
    while (n_counted < RANDOM_ITEMS) begin
      random_phase(phase);
      phase++;
    end
    wait_idle();

    $display("covered %0d sprite pixels: %0d drawn, %0d hidden by priority, %0d sprite ends",
             sb.n_pixels, sb.n_drawn, sb.n_hidden, sb.n_last);
    $display("plus %0d map loads over %0d register settings in %0d cycles",
             sb.n_loads, n_settings, cycles);
    if (sb.errors == 0) begin
      $display("** priority_masked_sprite_blit_unit: PASSED **");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("** priority_masked_sprite_blit_unit: FAILED **");
    end
    $finish;
  end

endmodule
